// File: rtl/core/vtfb_pkg.sv
// ----------------------------------------------------------------------------
// vtfb_pkg: shared definitions for the video trail feedback blend
// Widths, configuration register indexes, reset values and the
// configuration bundle that the control block hands to the datapath.
// ----------------------------------------------------------------------------
package vtfb_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int PLANE_W   = 2;
  localparam int ADDR_IN_W = 18;
  localparam int PHASE_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;
  localparam int PROD_W    = 2 * SAMPLE_W;

  localparam int STORE_DEPTH_DEF = 262144;

  // Full-scale weight and the shift that brings the weighted sum back to a sample.
  localparam logic [SAMPLE_W-1:0] MIX_FULL  = 8'd255;
  localparam int                  MIX_SHIFT = 8;

  localparam logic [PLANE_W-1:0] PLANE_LUMA = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPACITY     = 3'd0,
    CFG_PERIOD      = 3'd1,
    CFG_LUMA_LOW    = 3'd2,
    CFG_LUMA_HIGH   = 3'd3,
    CFG_CHROMA_LOW  = 3'd4,
    CFG_CHROMA_HIGH = 3'd5
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] RST_OPACITY     = 8'd150;
  localparam logic [PHASE_W-1:0]  RST_PERIOD      = 5'd8;
  localparam logic [SAMPLE_W-1:0] RST_LUMA_LOW    = 8'd16;
  localparam logic [SAMPLE_W-1:0] RST_LUMA_HIGH   = 8'd235;
  localparam logic [SAMPLE_W-1:0] RST_CHROMA_LOW  = 8'd16;
  localparam logic [SAMPLE_W-1:0] RST_CHROMA_HIGH = 8'd240;

  typedef struct packed {
    logic [SAMPLE_W-1:0] opacity;
    logic [SAMPLE_W-1:0] luma_low;
    logic [SAMPLE_W-1:0] luma_high;
    logic [SAMPLE_W-1:0] chroma_low;
    logic [SAMPLE_W-1:0] chroma_high;
  } cfg_t;

endpackage

// File: rtl/core/vtfb_ram.sv
// ----------------------------------------------------------------------------
// vtfb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module vtfb_ram #(
  parameter int WIDTH = vtfb_pkg::SAMPLE_W,
  parameter int DEPTH = vtfb_pkg::STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/vtfb_ctrl.sv
// ----------------------------------------------------------------------------
// vtfb_ctrl: configuration registers and frame phase counter
// Holds the six configuration registers and tracks which frame of the
// trail cycle the incoming samples belong to.
// ----------------------------------------------------------------------------
module vtfb_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vtfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vtfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_accept,
  input  logic                                item_frame_end,
  output vtfb_pkg::cfg_t                      cfg,
  output logic                                fresh
);

  vtfb_pkg::cfg_t                   cfg_r;
  logic [vtfb_pkg::PHASE_W-1:0]     period_r;
  logic [vtfb_pkg::PHASE_W-1:0]     phase_r;
  logic [vtfb_pkg::PHASE_W-1:0]     phase_nxt;
  logic [vtfb_pkg::PHASE_W-1:0]     phase_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.opacity     <= vtfb_pkg::RST_OPACITY;
      cfg_r.luma_low    <= vtfb_pkg::RST_LUMA_LOW;
      cfg_r.luma_high   <= vtfb_pkg::RST_LUMA_HIGH;
      cfg_r.chroma_low  <= vtfb_pkg::RST_CHROMA_LOW;
      cfg_r.chroma_high <= vtfb_pkg::RST_CHROMA_HIGH;
      period_r          <= vtfb_pkg::RST_PERIOD;
    end else if (cfg_valid) begin
      case (cfg_index)
        vtfb_pkg::CFG_OPACITY:     cfg_r.opacity     <= cfg_data;
        vtfb_pkg::CFG_PERIOD:      period_r          <= cfg_data[vtfb_pkg::PHASE_W-1:0];
        vtfb_pkg::CFG_LUMA_LOW:    cfg_r.luma_low    <= cfg_data;
        vtfb_pkg::CFG_LUMA_HIGH:   cfg_r.luma_high   <= cfg_data;
        vtfb_pkg::CFG_CHROMA_LOW:  cfg_r.chroma_low  <= cfg_data;
        vtfb_pkg::CFG_CHROMA_HIGH: cfg_r.chroma_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // A period of zero makes the wrap test always true, so every frame is fresh.
  always_comb begin
    phase_inc = phase_r + 1'b1;
    phase_nxt = phase_r;
    if (item_accept && item_frame_end) begin
      phase_nxt = (phase_inc >= period_r) ? '0 : phase_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  assign cfg   = cfg_r;
  assign fresh = (phase_r == '0);

  a_phase_holds_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && item_accept && !item_frame_end |=> $stable(phase_r))
    else $error("frame phase moved on a sample that does not end a frame");

endmodule

// File: rtl/core/vtfb_pipe.sv
// ----------------------------------------------------------------------------
// vtfb_pipe: four-stage blend datapath with the trail store
// Stage 1 captures and starts the address reduction, stage 2 forms the
// weighted products, stage 3 finishes the fresh blend and reads the store,
// stage 4 is the output register fed by the trail multiply-add.
// ----------------------------------------------------------------------------
module vtfb_pipe #(
  parameter int STORE_DEPTH = vtfb_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vtfb_pkg::cfg_t                    cfg,
  input  logic                              fresh,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vtfb_pkg::SAMPLE_W-1:0]     in_cur_sample,
  input  logic [vtfb_pkg::SAMPLE_W-1:0]     in_other_sample,
  input  logic [vtfb_pkg::PLANE_W-1:0]      in_plane,
  input  logic [vtfb_pkg::ADDR_IN_W-1:0]    in_store_addr,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vtfb_pkg::SAMPLE_W-1:0]     out_sample,
  output logic                              out_frame_end
);

  localparam int SW    = vtfb_pkg::SAMPLE_W;
  localparam int PW    = vtfb_pkg::PROD_W;
  localparam int IW    = vtfb_pkg::ADDR_IN_W;
  localparam int AW    = $clog2(STORE_DEPTH);
  // Floor reciprocal of the depth; the quotient estimate is short by at most one.
  localparam int unsigned Recip = (2 ** IW) / STORE_DEPTH;
  localparam logic [IW:0] DepthLo = (IW + 1)'(STORE_DEPTH);

  logic adv;

  // Stage 1
  logic                s1_valid_r;
  logic [SW-1:0]       s1_cur_r, s1_oth_r;
  logic [1:0]          s1_plane_r;
  logic [IW-1:0]       s1_addr_r, s1_quot_r;
  logic                s1_fend_r, s1_fresh_r;
  logic [2*IW-1:0]     quot_prod;

  // Stage 2
  logic                s2_valid_r;
  logic [PW-1:0]       s2_cur_prod_r, s2_oth_prod_r;
  logic [1:0]          s2_plane_r;
  logic [AW-1:0]       s2_addr_r;
  logic                s2_fend_r, s2_fresh_r;
  logic [2*IW:0]       quot_depth;
  logic [IW:0]         rem_raw, rem_fix;
  logic [SW-1:0]       w_inv;

  // Stage 3
  logic                s3_valid_r;
  logic [PW-1:0]       s3_cur_prod_r;
  logic [SW-1:0]       s3_fresh_res_r;
  logic [AW-1:0]       s3_addr_r;
  logic                s3_fend_r, s3_fresh_r;
  logic [PW:0]         fresh_sum;
  logic [SW-1:0]       fresh_mix, clamp_lo, clamp_hi, fresh_res;

  // Stage 4 (output)
  logic                s4_valid_r;
  logic [SW-1:0]       s4_sample_r;
  logic [AW-1:0]       s4_addr_r;
  logic                s4_fend_r;

  // Trail path
  logic [AW-1:0]       rd_addr;
  logic [SW-1:0]       rd_data, trail;
  logic [PW-1:0]       trail_prod;
  logic [PW:0]         trail_sum;
  logic [SW-1:0]       res_nxt;

  assign adv      = !s4_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // Stage 1: quotient estimate of the address by the store depth.
  assign quot_prod = (2 * IW)'(in_store_addr) * (2 * IW)'(Recip);

  // Stage 2: remainder with one correction step, and the two weighted products.
  always_comb begin
    quot_depth = (2 * IW + 1)'(s1_quot_r) * (2 * IW + 1)'(DepthLo);
    rem_raw    = {1'b0, s1_addr_r} - quot_depth[IW:0];
    rem_fix    = rem_raw;
    if (32'(rem_raw) >= 32'(STORE_DEPTH)) begin
      rem_fix = rem_raw - DepthLo;
    end
    w_inv = vtfb_pkg::MIX_FULL - cfg.opacity;
  end

  // Stage 3: fresh blend, raised to the low bound and then lowered to the high one.
  always_comb begin
    fresh_sum = (PW + 1)'(s2_cur_prod_r) + (PW + 1)'(s2_oth_prod_r);
    fresh_mix = SW'(fresh_sum >> vtfb_pkg::MIX_SHIFT);
    if (s2_plane_r == vtfb_pkg::PLANE_LUMA) begin
      clamp_lo = cfg.luma_low;
      clamp_hi = cfg.luma_high;
    end else begin
      clamp_lo = cfg.chroma_low;
      clamp_hi = cfg.chroma_high;
    end
    fresh_res = fresh_mix;
    if (fresh_res < clamp_lo) begin
      fresh_res = clamp_lo;
    end
    if (fresh_res > clamp_hi) begin
      fresh_res = clamp_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cur_r   <= in_cur_sample;
      s1_oth_r   <= in_other_sample;
      s1_plane_r <= in_plane;
      s1_addr_r  <= in_store_addr;
      s1_quot_r  <= quot_prod[2*IW-1:IW];
      s1_fend_r  <= in_frame_end;
      s1_fresh_r <= fresh;

      s2_cur_prod_r <= PW'(w_inv) * PW'(s1_cur_r);
      s2_oth_prod_r <= PW'(cfg.opacity) * PW'(s1_oth_r);
      s2_plane_r    <= s1_plane_r;
      s2_addr_r     <= AW'(rem_fix);
      s2_fend_r     <= s1_fend_r;
      s2_fresh_r    <= s1_fresh_r;

      s3_cur_prod_r  <= s2_cur_prod_r;
      s3_fresh_res_r <= fresh_res;
      s3_addr_r      <= s2_addr_r;
      s3_fend_r      <= s2_fend_r;
      s3_fresh_r     <= s2_fresh_r;

      s4_sample_r <= res_nxt;
      s4_addr_r   <= s3_addr_r;
      s4_fend_r   <= s3_fend_r;
    end
  end

  // While stalled the store is read again at the stage 3 address, so the
  // read data never misses a write older than the one held in stage 4.
  assign rd_addr = adv ? s2_addr_r : s3_addr_r;

  vtfb_ram #(
    .WIDTH (SW),
    .DEPTH (STORE_DEPTH)
  ) u_trail_store (
    .clk     (clk),
    .wr_en   (adv && s3_valid_r),
    .wr_addr (s3_addr_r),
    .wr_data (res_nxt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Stage 4: the trail sample comes from the store, or from stage 4 when it
  // holds the most recent write to the same address.
  always_comb begin
    trail      = (s4_valid_r && (s4_addr_r == s3_addr_r)) ? s4_sample_r : rd_data;
    trail_prod = PW'(cfg.opacity) * PW'(trail);
    trail_sum  = (PW + 1)'(s3_cur_prod_r) + (PW + 1)'(trail_prod);
    res_nxt    = s3_fresh_r ? s3_fresh_res_r : SW'(trail_sum >> vtfb_pkg::MIX_SHIFT);
  end

  assign out_valid     = s4_valid_r;
  assign out_sample    = s4_sample_r;
  assign out_frame_end = s4_fend_r;

  a_addr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (32'(s2_addr_r) < 32'(STORE_DEPTH)))
    else $error("reduced store address is outside the store");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=>
      $stable(s2_valid_r) && $stable(s3_valid_r) && $stable(s3_addr_r))
    else $error("pipeline moved while the output was stalled");

  a_valid_travels: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && adv |=> (s4_valid_r == $past(s3_valid_r)))
    else $error("valid bit lost or invented between stage 3 and the output");

endmodule

// File: rtl/core/video_trail_feedback_blend_core.sv
// ----------------------------------------------------------------------------
// video_trail_feedback_blend_core: per-sample video trail blend
// Top level: configuration registers, frame phase and the blend pipeline
// with its trail store.
// ----------------------------------------------------------------------------
// Usage. Samples of a planar YCbCr frame enter on the in_ channel, one
// transaction per sample, with the matching second-frame sample, the plane,
// the trail store address and a frame end mark on the last sample. Each
// input transaction produces exactly one out_ transaction, in order.
// Configuration is written on the cfg_ channel (always ready) while the
// block is idle; index 0 opacity, 1 period, 2/3 luma bounds, 4/5 chroma.
// An accepted sample passes through the stage 1, 2 and 3 registers into the
// output register on out_. Throughput: one sample per cycle, sustained while
// out_ready holds; the limit is the trail loop in the last stage, where
// a result held in the output register is forwarded into the next sample's
// multiply-add when addresses match.
// Reset (rst_n low, synchronous) empties the pipeline, loads the register
// defaults and sets the frame phase to zero; the trail store is not cleared,
// and the user must read it only where a sample wrote it before (unchecked).
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module video_trail_feedback_blend_core #(
  parameter int STORE_DEPTH = vtfb_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vtfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vtfb_pkg::CFG_DATA_W-1:0]   cfg_data,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vtfb_pkg::SAMPLE_W-1:0]     in_cur_sample,
  input  logic [vtfb_pkg::SAMPLE_W-1:0]     in_other_sample,
  input  logic [vtfb_pkg::PLANE_W-1:0]      in_plane,
  input  logic [vtfb_pkg::ADDR_IN_W-1:0]    in_store_addr,
  input  logic                              in_frame_end,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vtfb_pkg::SAMPLE_W-1:0]     out_sample,
  output logic                              out_frame_end
);

  vtfb_pkg::cfg_t cfg;
  logic           fresh;

  // The frame phase is sampled when a sample is accepted, so a frame end
  // mark changes the mode from the very next sample on.
  vtfb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_accept    (in_valid && in_ready),
    .item_frame_end (in_frame_end),
    .cfg            (cfg),
    .fresh          (fresh)
  );

  // Fresh frames blend with the second frame and clamp to the plane's bounds;
  // other frames blend with the stored trail. Every result is written back.
  vtfb_pipe #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .fresh           (fresh),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cur_sample   (in_cur_sample),
    .in_other_sample (in_other_sample),
    .in_plane        (in_plane),
    .in_store_addr   (in_store_addr),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_frame_end   (out_frame_end)
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for video_trail_feedback_blend_core
// Streams planar YCbCr samples through the trail blend under several register
// settings. A scoreboard class tracks its own trail memory, frame phase and
// registers, predicts every output transaction, and compares the results in
// order as they leave the block. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vtfb_pkg::*;

  // One input transaction, field by field, at the block's port widths.
  typedef struct packed {
    logic [SAMPLE_W-1:0]  cur;
    logic [SAMPLE_W-1:0]  other;
    logic [PLANE_W-1:0]   plane;
    logic [ADDR_IN_W-1:0] addr;
    logic                 frame_end;
  } blend_in_t;

  // One output transaction.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_end;
  } blend_out_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps a private copy of everything the block remembers:
  // the registers, the frame phase and every trail entry written so far.
  // Each accepted sample is blended here the moment it enters the block, and
  // the result is queued until the matching output transaction shows up.
  // --------------------------------------------------------------------------
  class trail_scoreboard;
    logic [SAMPLE_W-1:0] opacity;
    logic [PHASE_W-1:0]  period_len;
    logic [SAMPLE_W-1:0] luma_lo, luma_hi, chroma_lo, chroma_hi;
    logic [PHASE_W-1:0]  phase_cnt;
    logic [SAMPLE_W-1:0] trail_mem [int];
    int                  written_addrs [$];
    blend_out_t          due_results [$];
    int errors, fresh_cnt, trail_cnt, frame_cnt, reg_writes, compared;

    function new();
      opacity    = RST_OPACITY;
      period_len = RST_PERIOD;
      luma_lo    = RST_LUMA_LOW;
      luma_hi    = RST_LUMA_HIGH;
      chroma_lo  = RST_CHROMA_LOW;
      chroma_hi  = RST_CHROMA_HIGH;
      phase_cnt  = '0;
      errors = 0; fresh_cnt = 0; trail_cnt = 0; frame_cnt = 0;
      reg_writes = 0; compared = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_OPACITY:     opacity    = data;
        CFG_PERIOD:      period_len = data[PHASE_W-1:0];
        CFG_LUMA_LOW:    luma_lo    = data;
        CFG_LUMA_HIGH:   luma_hi    = data;
        CFG_CHROMA_LOW:  chroma_lo  = data;
        CFG_CHROMA_HIGH: chroma_hi  = data;
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] blend_value(logic [SAMPLE_W-1:0] a,
                                              logic [SAMPLE_W-1:0] b);
      int unsigned acc;
      acc = (MIX_FULL - opacity) * a + opacity * b;
      return SAMPLE_W'(acc >> MIX_SHIFT);
    endfunction

    // The floor is applied first, so with inverted bounds the ceiling wins.
    function logic [SAMPLE_W-1:0] bound(logic [SAMPLE_W-1:0] v,
                                        logic [SAMPLE_W-1:0] lo,
                                        logic [SAMPLE_W-1:0] hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
    endfunction

    function bit holds(int addr);
      return trail_mem.exists(addr);
    endfunction

    function int pick_written();
      return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    endfunction

    function void log_sample(blend_in_t s);
      int                  a;
      logic [SAMPLE_W-1:0] res;
      blend_out_t          r;
      a = int'(s.addr);
      if (phase_cnt == '0) begin
        // Fresh frame: mix with the second frame and clamp to the plane's
        // range. Plane three goes through the chroma bounds.
        res = blend_value(s.cur, s.other);
        if (s.plane == PLANE_LUMA) res = bound(res, luma_lo, luma_hi);
        else res = bound(res, chroma_lo, chroma_hi);
        fresh_cnt++;
      end else begin
        res = blend_value(s.cur, trail_mem.exists(a) ? trail_mem[a] : '0);
        trail_cnt++;
      end
      if (!trail_mem.exists(a)) written_addrs.push_back(a);
      trail_mem[a] = res;
      if (s.frame_end) begin
        frame_cnt++;
        phase_cnt = phase_cnt + 1'b1;
        // A period of zero acts like one: every frame is fresh.
        if (phase_cnt >= period_len) phase_cnt = '0;
      end
      r.sample    = res;
      r.frame_end = s.frame_end;
      due_results.push_back(r);
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] sample, logic frame_end);
      blend_out_t want;
      if (due_results.size() == 0) begin
        $error("output transaction with nothing outstanding: sample %0d", sample);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compared++;
      if (sample !== want.sample) begin
        $error("out_sample: expected %0d, got %0d", want.sample, sample);
        errors++;
      end
      if (frame_end !== want.frame_end) begin
        $error("out_frame_end: expected %0d, got %0d", want.frame_end, frame_end);
        errors++;
      end
    endfunction

    function void close_out();
      if (due_results.size() != 0) begin
        $error("%0d results never arrived", due_results.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_cur_sample = '0;
  logic [SAMPLE_W-1:0]   in_other_sample = '0;
  logic [PLANE_W-1:0]    in_plane = '0;
  logic [ADDR_IN_W-1:0]  in_store_addr = '0;
  logic                  in_frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample;
  logic                  out_frame_end;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  video_trail_feedback_blend_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cur_sample   (in_cur_sample),
    .in_other_sample (in_other_sample),
    .in_plane        (in_plane),
    .in_store_addr   (in_store_addr),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample      (out_sample),
    .out_frame_end   (out_frame_end)
  );

  trail_scoreboard board;

  // While calm is set, neither side inserts gaps, so the pipeline runs at
  // full rate and the trail forwarding path is hit back to back.
  bit calm = 1'b0;

  // Frame layout reused across frames: addresses and planes of one frame.
  int unsigned      lay_addr [$];
  logic [PLANE_W-1:0] lay_plane [$];

  // --------------------------------------------------------------------------
  // Monitor. Every transaction on any channel is seen at the rising edge,
  // before the block's registers update, so the scoreboard sees the same
  // values the block does.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      blend_in_t s;
      if (cfg_valid && cfg_ready) board.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) begin
        s.cur       = in_cur_sample;
        s.other     = in_other_sample;
        s.plane     = in_plane;
        s.addr      = in_store_addr;
        s.frame_end = in_frame_end;
        board.log_sample(s);
      end
      if (out_valid && out_ready) board.check_result(out_sample, out_frame_end);
    end
  end

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // Byte values lean toward the two extremes now and then.
  function automatic logic [SAMPLE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: before each transaction the receiver may hold ready low for
  // a random number of cycles, then waits for the block to deliver.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = pause_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a falling edge; optionally idles first, then presents
  // the sample and holds it until the transaction completes. Valid is left
  // high so that a following sample can go out in the very next cycle.
  // --------------------------------------------------------------------------
  task automatic send_sample(blend_in_t s);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cur_sample   <= s.cur;
    in_other_sample <= s.other;
    in_plane        <= s.plane;
    in_store_addr   <= s.addr;
    in_frame_end    <= s.frame_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [SAMPLE_W-1:0] cur, logic [SAMPLE_W-1:0] other,
                             logic [PLANE_W-1:0] plane, logic [ADDR_IN_W-1:0] addr,
                             logic frame_end);
    blend_in_t s;
    s.cur = cur; s.other = other; s.plane = plane; s.addr = addr;
    s.frame_end = frame_end;
    send_sample(s);
  endtask

  // Stop sending and hold off until every outstanding result has come back,
  // then keep idling so the pipeline is fully empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg_tx(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [SAMPLE_W-1:0] opac, logic [PHASE_W-1:0] per,
                              logic [SAMPLE_W-1:0] ylo, logic [SAMPLE_W-1:0] yhi,
                              logic [SAMPLE_W-1:0] clo, logic [SAMPLE_W-1:0] chi);
    write_reg_tx(CFG_OPACITY, opac);
    write_reg_tx(CFG_PERIOD, CFG_DATA_W'(per));
    write_reg_tx(CFG_LUMA_LOW, ylo);
    write_reg_tx(CFG_LUMA_HIGH, yhi);
    write_reg_tx(CFG_CHROMA_LOW, clo);
    write_reg_tx(CFG_CHROMA_HIGH, chi);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic. Most frames walk a fixed layout of addresses, so trail
  // frames revisit exactly what the fresh frame wrote. A new layout is only
  // picked on a fresh frame, or when none exists. Some frames are noise:
  // random addresses and frame end marks in odd places. On a trail frame
  // an address is only used once written: unwritten entries are undefined.
  // --------------------------------------------------------------------------
  task automatic run_frames(int count);
    int          sent, size, k;
    int unsigned base;
    blend_in_t   s;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if ($urandom_range(0, 7) == 0) begin
        size = $urandom_range(1, 8);
        for (k = 0; k < size; k++) begin
          s.cur   = rand_byte();
          s.other = rand_byte();
          s.plane = PLANE_W'($urandom_range(0, 3));
          if (board.phase_cnt == '0 && $urandom_range(0, 1) == 1)
            s.addr = ADDR_IN_W'($urandom);
          else
            s.addr = ADDR_IN_W'(board.pick_written());
          s.frame_end = ($urandom_range(0, 3) == 0);
          send_sample(s);
          sent++;
        end
      end else begin
        if (lay_addr.size() == 0 ||
            (board.phase_cnt == '0 && $urandom_range(0, 1) == 1)) begin
          lay_addr.delete();
          lay_plane.delete();
          size = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                             : $urandom_range(1, 12);
          base = $urandom;
          for (k = 0; k < size; k++) begin
            // Occasional repeats inside a frame exercise the forwarding of a
            // fresh result into the next read of the same entry.
            if (k > 0 && $urandom_range(0, 5) == 0)
              lay_addr.push_back(lay_addr[$urandom_range(0, k - 1)]);
            else
              lay_addr.push_back((base + k) % STORE_DEPTH_DEF);
            if ($urandom_range(0, 9) == 0) lay_plane.push_back(PLANE_W'(3));
            else lay_plane.push_back(PLANE_W'((k * 3) / size));
          end
        end
        for (k = 0; k < lay_addr.size(); k++) begin
          s.cur       = rand_byte();
          s.other     = rand_byte();
          s.plane     = lay_plane[k];
          s.addr      = ADDR_IN_W'(lay_addr[k]);
          s.frame_end = (k == lay_addr.size() - 1);
          if (board.phase_cnt != '0 && !board.holds(int'(s.addr)))
            s.addr = ADDR_IN_W'(board.pick_written());
          send_sample(s);
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, a directed warm-up under the reset defaults, then
  // phases of random traffic, each under its own register setting. Between
  // phases the sender waits for the block to go idle before reprogramming.
  // --------------------------------------------------------------------------
  initial begin
    int p, wait_cnt;
    board = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fresh frame: luma at both extremes, plane one high, plane two low, plane
    // three through the chroma bounds, and both ends of the address range.
    send_fields(8'd0,   8'd0,   2'd0, 18'd0,      1'b0);
    send_fields(8'd255, 8'd255, 2'd0, 18'd1,      1'b0);
    send_fields(8'd255, 8'd255, 2'd1, 18'd2,      1'b0);
    send_fields(8'd0,   8'd0,   2'd2, 18'h3FFFF,  1'b0);
    send_fields(8'd255, 8'd0,   2'd3, 18'd3,      1'b0);
    send_fields(8'd128, 8'd64,  2'd0, 18'd4,      1'b1);
    // Trail frame over the same entries, current sample at its extremes.
    send_fields(8'd0,   8'd255, 2'd0, 18'd0,      1'b0);
    send_fields(8'd255, 8'd0,   2'd0, 18'd1,      1'b0);
    send_fields(8'd255, 8'd255, 2'd1, 18'd2,      1'b0);
    send_fields(8'd0,   8'd0,   2'd2, 18'h3FFFF,  1'b0);
    send_fields(8'd255, 8'd255, 2'd3, 18'd3,      1'b0);
    send_fields(8'd128, 8'd7,   2'd0, 18'd4,      1'b1);
    // One entry hit several times in a row, then another entry.
    send_fields(8'd255, 8'd0,   2'd0, 18'd4,      1'b0);
    send_fields(8'd255, 8'd0,   2'd0, 18'd4,      1'b0);
    send_fields(8'd0,   8'd0,   2'd0, 18'd4,      1'b0);
    send_fields(8'd90,  8'd0,   2'd0, 18'd4,      1'b0);
    send_fields(8'd17,  8'd0,   2'd1, 18'd2,      1'b1);
    run_frames(150);

    for (p = 1; p <= 10; p++) begin
      drain();
      case (p)
        1: program_regs(8'd0,   5'd1,  8'd0,   8'd255, 8'd0,   8'd255);
        // Inverted bounds on both planes: the ceiling wins.
        2: program_regs(8'd255, 5'd25, 8'd235, 8'd16,  8'd200, 8'd100);
        // A period of zero makes every frame fresh.
        3: program_regs(8'd128, 5'd0,  8'd16,  8'd235, 8'd16,  8'd240);
        4: program_regs(8'd255, 5'd2,  8'd255, 8'd255, 8'd0,   8'd0);
        default: begin
          if ($urandom_range(0, 4) == 0)
            program_regs(rand_byte(), PHASE_W'($urandom_range(0, 25)),
                         rand_byte(), rand_byte(), rand_byte(), rand_byte());
          else
            program_regs(rand_byte(), PHASE_W'($urandom_range(1, 6)),
                         SAMPLE_W'($urandom_range(0, 80)),
                         SAMPLE_W'($urandom_range(160, 255)),
                         SAMPLE_W'($urandom_range(0, 80)),
                         SAMPLE_W'($urandom_range(160, 255)));
        end
      endcase
      run_frames(160);
    end

    // Let the last results out, within a bound, then settle.
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (board.due_results.size() != 0 && wait_cnt < 5000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (10) @(negedge clk);
    board.close_out();

    $display("Run covered %0d samples (%0d fresh blends, %0d trail blends) in %0d frames,",
             board.fresh_cnt + board.trail_cnt, board.fresh_cnt, board.trail_cnt,
             board.frame_cnt);
    $display("with %0d register writes and %0d results compared.",
             board.reg_writes, board.compared);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with every gap at its longest.
  initial begin
    #10_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
